@@ sv/pcd_pkg.sv @@
package pcd_pkg;

  // Field widths fixed by the stream format
  localparam int unsigned SAMPLE_FIELD_BITS = 12;
  localparam int unsigned METRIC_BITS       = 16;

  // Fraction bits of the squared metric test: m^2 * 8E <= P^2 * 2^32
  localparam int unsigned FRAC_SHIFT = 2 * METRIC_BITS;

  // Pulse positions of the preamble inside the window, oldest sample first
  localparam int unsigned PULSE_COUNT = 8;
  localparam int unsigned PULSE_POS [PULSE_COUNT] = '{0, 1, 3, 4, 14, 15, 18, 19};

  // Sequencer of the top level
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQ_OLD,
    ST_SQ_NEW,
    ST_UPDATE,
    ST_PSUM,
    ST_SQ_P,
    ST_ROOT_GO,
    ST_ROOT_WAIT,
    ST_FIN
  } state_t;

endpackage

@@ sv/pcd_root_div.sv @@
// Bit-serial search for the largest m < 2^16 with m^2 * k <= psq * 2^32.
// Each metric bit runs an add phase, then a compare-and-subtract phase.
module pcd_root_div #(
  parameter int unsigned KW = 32,
  parameter int unsigned PW = 15
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  input  logic [KW-1:0]                      k,
  input  logic [2*PW-1:0]                    psq,
  output logic                               done,
  output logic [pcd_pkg::METRIC_BITS-1:0]    metric
);

  localparam int unsigned WW = KW + pcd_pkg::FRAC_SHIFT;
  localparam int unsigned BW = $clog2(pcd_pkg::METRIC_BITS);
  localparam int unsigned B_SHIFT = 2 * (pcd_pkg::METRIC_BITS - 1);

  logic          busy;
  logic          phase;
  logic [BW-1:0] bitcnt;
  logic [WW-1:0] rem;    // psq*2^32 - m^2*k
  logic [WW-1:0] acc_a;  // m*k << (j+1)
  logic [WW-1:0] acc_b;  // k << (2j)
  logic [WW-1:0] delta;  // trial increment for bit j

  // Control: run one phase pair per metric bit, pulse done at the end
  always_ff @(posedge clk) begin
    if (rst) begin
      busy   <= 1'b0;
      phase  <= 1'b0;
      done   <= 1'b0;
      bitcnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy   <= 1'b1;
        phase  <= 1'b0;
        bitcnt <= BW'(pcd_pkg::METRIC_BITS - 1);
      end else if (busy) begin
        phase <= ~phase;
        if (phase) begin
          if (bitcnt == '0) begin
            busy <= 1'b0;
            done <= 1'b1;
          end else begin
            bitcnt <= bitcnt - 1'b1;
          end
        end
      end
    end
  end

  // Datapath: add trial term, then compare and subtract
  always_ff @(posedge clk) begin
    if (start) begin
      rem    <= WW'(psq) << pcd_pkg::FRAC_SHIFT;
      acc_a  <= '0;
      acc_b  <= WW'(k) << B_SHIFT;
      metric <= '0;
    end else if (busy) begin
      if (!phase) begin
        delta <= acc_a + acc_b;
      end else begin
        if (delta <= rem) begin
          rem            <= rem - delta;
          acc_a          <= (acc_a >> 1) + acc_b;
          metric[bitcnt] <= 1'b1;
        end else begin
          acc_a <= acc_a >> 1;
        end
        acc_b <= acc_b >> 2;
      end
    end
  end

endmodule

@@ sv/preamble_correlation_detector_core.sv @@
// Channel   Dir  Beat payload                                  Handshake
// s_*       in   tdata: sample[11:0], zero pad; tuser: restart tvalid/tready
// m_*       out  tdata: metric[15:0]; tuser: energy_zero       tvalid/tready
//
// While the window fills, a sample passes the old-square, new-square and update
// steps; when the full window has zero energy the pulse-sum step follows, and
// otherwise six sequencer steps share one squarer for the old sample, the new
// sample and the pulse sum, then the root/divide unit resolves the 16 metric bits.
// s_tready is high only between samples. A finished result sits in the output
// register; the next sample is taken meanwhile, and its result waits in the FIN step
// until the previous beat has left. Reset empties the window at once.
module preamble_correlation_detector_core #(
  parameter int unsigned WINDOW_LEN  = 32,
  parameter int unsigned SAMPLE_BITS = 12
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [11:0] sample, [15:12] zero
  input  logic        s_tuser,   // [0] restart
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [15:0] metric
  output logic        m_tuser    // [0] energy_zero
);

  localparam int unsigned AW = $clog2(WINDOW_LEN);
  localparam int unsigned CW = $clog2(WINDOW_LEN + 1);
  localparam int unsigned EW = 2 * SAMPLE_BITS + AW;
  localparam int unsigned KW = EW + 3;
  localparam int unsigned PW = SAMPLE_BITS + 3;

  pcd_pkg::state_t state, state_next;

  logic [SAMPLE_BITS-1:0] win [WINDOW_LEN];
  logic [SAMPLE_BITS-1:0] s_reg;
  logic [CW-1:0]          fill;
  logic [EW-1:0]          energy;
  logic [PW-1:0]          psum;
  logic [2*PW-1:0]        sq;
  logic [PW-1:0]          mul_a;
  logic [PW-1:0]          psum_c;
  logic                   res_zero;
  logic                   full;
  logic                   root_start;
  logic                   root_done;
  logic [pcd_pkg::METRIC_BITS-1:0] root_metric;
  logic                   s_fire;
  logic                   out_free;

  assign s_fire   = s_tvalid && s_tready;
  assign full     = (fill == CW'(WINDOW_LEN));
  assign out_free = !m_tvalid || m_tready;

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      pcd_pkg::ST_IDLE:      if (s_fire) state_next = pcd_pkg::ST_SQ_OLD;
      pcd_pkg::ST_SQ_OLD:    state_next = pcd_pkg::ST_SQ_NEW;
      pcd_pkg::ST_SQ_NEW:    state_next = pcd_pkg::ST_UPDATE;
      pcd_pkg::ST_UPDATE:    state_next = (full || fill == CW'(WINDOW_LEN - 1))
                                          ? pcd_pkg::ST_PSUM : pcd_pkg::ST_IDLE;
      pcd_pkg::ST_PSUM:      state_next = (energy == '0) ? pcd_pkg::ST_FIN
                                                         : pcd_pkg::ST_SQ_P;
      pcd_pkg::ST_SQ_P:      state_next = pcd_pkg::ST_ROOT_GO;
      pcd_pkg::ST_ROOT_GO:   state_next = pcd_pkg::ST_ROOT_WAIT;
      pcd_pkg::ST_ROOT_WAIT: if (root_done) state_next = pcd_pkg::ST_FIN;
      pcd_pkg::ST_FIN:       if (out_free) state_next = pcd_pkg::ST_IDLE;
      default:               state_next = pcd_pkg::ST_IDLE;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    s_tready   = 1'b0;
    root_start = 1'b0;
    mul_a      = psum;
    unique case (state)
      pcd_pkg::ST_IDLE:    s_tready = 1'b1;
      pcd_pkg::ST_SQ_OLD:  mul_a = PW'(win[0]);
      pcd_pkg::ST_SQ_NEW:  mul_a = PW'(s_reg);
      pcd_pkg::ST_ROOT_GO: root_start = 1'b1;
      default:             mul_a = psum;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pcd_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Shared squarer
  always_ff @(posedge clk) begin
    sq <= mul_a * mul_a;
  end

  // Pulse sum over the fixed taps
  always_comb begin
    psum_c = '0;
    for (int i = 0; i < pcd_pkg::PULSE_COUNT; i++) begin
      psum_c = psum_c + PW'(win[AW'(pcd_pkg::PULSE_POS[i])]);
    end
  end

  // Window control: fill count and running energy
  always_ff @(posedge clk) begin
    if (rst) begin
      fill   <= '0;
      energy <= '0;
    end else begin
      if (s_fire && s_tuser) begin
        fill   <= '0;
        energy <= '0;
      end
      if (state == pcd_pkg::ST_SQ_NEW && full) begin
        energy <= energy - EW'(sq);
      end
      if (state == pcd_pkg::ST_UPDATE) begin
        energy <= energy + EW'(sq);
        if (!full) begin
          fill <= fill + 1'b1;
        end
      end
    end
  end

  // Sample capture, window shift and pulse sum
  always_ff @(posedge clk) begin
    if (s_fire) begin
      s_reg <= SAMPLE_BITS'(s_tdata[pcd_pkg::SAMPLE_FIELD_BITS-1:0]);
    end
    if (state == pcd_pkg::ST_UPDATE) begin
      for (int i = 0; i < WINDOW_LEN - 1; i++) begin
        win[i] <= win[i+1];
      end
      win[WINDOW_LEN-1] <= s_reg;
    end
    if (state == pcd_pkg::ST_PSUM) begin
      psum     <= psum_c;
      res_zero <= (energy == '0);
    end
  end

  pcd_root_div #(
    .KW (KW),
    .PW (PW)
  ) u_root (
    .clk    (clk),
    .rst    (rst),
    .start  (root_start),
    .k      ({energy, 3'b000}),
    .psq    (sq),
    .done   (root_done),
    .metric (root_metric)
  );

  // Output register: load when the previous beat has left
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == pcd_pkg::ST_FIN && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == pcd_pkg::ST_FIN && out_free) begin
      m_tdata <= res_zero ? '0 : root_metric;
      m_tuser <= res_zero;
    end
  end

endmodule

@@ sv/pcd_checker.sv @@
module pcd_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata,
  input logic        m_tuser
);

  // Hold a stalled result beat
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result beat changed");

  // Zero energy forces a zero metric
  a_zero_metric: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata == 16'd0)
    else $error("energy_zero beat with nonzero metric");

  // Drop ready while a sample is being worked on
  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input taken on consecutive cycles");

  // No result can appear right after a sample is taken
  a_no_early: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !$rose(m_tvalid))
    else $error("result appeared one cycle after input");

  // Come out of reset ready for a sample with no result pending
  a_rdy_after_rst: assert property (@(posedge clk)
    $fell(rst) |-> s_tready && !m_tvalid)
    else $error("block not idle after reset");

endmodule

bind preamble_correlation_detector_core pcd_checker u_pcd_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
